// File: src/qco_pkg.sv
// shared constants, types and the arctangent table for the corner ordering unit
`timescale 1ns / 1ps
package qco_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int PRE_SHIFT = 8;
	localparam int GUARD_BITS = 4;
	localparam int NUM_CORNERS = 4;
	localparam int NUM_LANES = NUM_CORNERS + 1;

	typedef enum logic [1:0] {
		ST_PASS     = 2'd0,
		ST_QUAD     = 2'd1,
		ST_FALLBACK = 2'd2
	} status_t;

	typedef logic [NUM_CORNERS-1:0][31:0] corner_set_t;

	typedef struct packed {
		logic        pass;
		corner_set_t crn;
	} side_t;

	typedef struct packed {
		status_t     status;
		corner_set_t crn;
	} res_word_t;

	// atan(2^-idx) as a binary angle of aw bits, rounded to nearest
	function automatic logic [31:0] atan_unit(input int idx, input int aw);
		logic [31:0] base;
		logic [32:0] t;
		unique case (idx)
			0: base = 32'd536870912;
			1: base = 32'd316933406;
			2: base = 32'd167458907;
			3: base = 32'd85004756;
			4: base = 32'd42667331;
			5: base = 32'd21354465;
			6: base = 32'd10679838;
			7: base = 32'd5340245;
			8: base = 32'd2670163;
			9: base = 32'd1335087;
			10: base = 32'd667544;
			11: base = 32'd333772;
			12: base = 32'd166886;
			13: base = 32'd83443;
			14: base = 32'd41722;
			15: base = 32'd20861;
			16: base = 32'd10430;
			17: base = 32'd5215;
			18: base = 32'd2608;
			19: base = 32'd1304;
			20: base = 32'd652;
			21: base = 32'd326;
			22: base = 32'd163;
			23: base = 32'd81;
			default: base = '0;
		endcase
		t = {1'b0, base} + (33'd1 << (31 - aw));
		return 32'(t >> (32 - aw));
	endfunction

endpackage

// File: src/qco_in_if.sv
// candidate channel: quad centre, reference and four corners
`timescale 1ns / 1ps
interface qco_in_if;
	logic        valid;
	logic        ready;
	logic        both_valid;
	logic [31:0] center_point;
	logic [31:0] ref_point;
	logic [31:0] corner_a;
	logic [31:0] corner_b;
	logic [31:0] corner_c;
	logic [31:0] corner_d;

	modport source (
		output valid, both_valid, center_point, ref_point,
		output corner_a, corner_b, corner_c, corner_d,
		input ready
	);
	modport sink (
		input valid, both_valid, center_point, ref_point,
		input corner_a, corner_b, corner_c, corner_d,
		output ready
	);
endinterface

// File: src/qco_out_if.sv
// result channel: status and ordered corners
`timescale 1ns / 1ps
interface qco_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_first;
	logic [31:0] out_second;
	logic [31:0] out_third;
	logic [31:0] out_fourth;

	modport source (
		output valid, status, out_first, out_second, out_third, out_fourth,
		input ready
	);
	modport sink (
		input valid, status, out_first, out_second, out_third, out_fourth,
		output ready
	);
endinterface

// File: src/qco_cordic.sv
// pipelined vectoring cordic lane, one iteration per stage
`timescale 1ns / 1ps
module qco_cordic import qco_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH:0]   dx,
	input  logic signed [COORD_WIDTH:0]   dy,
	output logic [ANGLE_WIDTH-1:0]        angle
);
	localparam int DW = COORD_WIDTH + PRE_SHIFT + GUARD_BITS;
	localparam logic [ANGLE_WIDTH-1:0] Z_HALF = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

	logic signed [DW-1:0]   x_s [0:ANGLE_WIDTH];
	logic signed [DW-1:0]   y_s [0:ANGLE_WIDTH];
	logic [ANGLE_WIDTH-1:0] z_s [0:ANGLE_WIDTH];
	logic signed [DW-1:0]   x0;
	logic signed [DW-1:0]   y0;

	assign x0 = DW'(dx) <<< PRE_SHIFT;
	assign y0 = DW'(dy) <<< PRE_SHIFT;

	// pre-rotation into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			if (x0 < 0) begin
				x_s[0] <= -x0;
				y_s[0] <= -y0;
				z_s[0] <= Z_HALF;
			end else begin
				x_s[0] <= x0;
				y_s[0] <= y0;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= ANGLE_WIDTH; k++) begin : g_iter
		localparam logic [ANGLE_WIDTH-1:0] T = ANGLE_WIDTH'(atan_unit(k - 1, ANGLE_WIDTH));
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[k-1] > 0) begin
					x_s[k] <= x_s[k-1] + (y_s[k-1] >>> (k - 1));
					y_s[k] <= y_s[k-1] - (x_s[k-1] >>> (k - 1));
					z_s[k] <= z_s[k-1] + T;
				end else if (y_s[k-1] < 0) begin
					x_s[k] <= x_s[k-1] - (y_s[k-1] >>> (k - 1));
					y_s[k] <= y_s[k-1] + (x_s[k-1] >>> (k - 1));
					z_s[k] <= z_s[k-1] - T;
				end else begin
					x_s[k] <= x_s[k-1];
					y_s[k] <= y_s[k-1];
					z_s[k] <= z_s[k-1];
				end
			end
		end
	end

	assign angle = z_s[ANGLE_WIDTH];
endmodule

// File: src/qco_rank.sv
// stable sort of four relative angles by rank counting
`timescale 1ns / 1ps
module qco_rank import qco_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic signed [ANGLE_WIDTH:0] ang    [NUM_CORNERS],
	output logic [1:0]                  order  [NUM_CORNERS],
	output logic signed [ANGLE_WIDTH:0] sorted [NUM_CORNERS]
);
	logic [1:0] rank [NUM_CORNERS];

	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NUM_CORNERS; j++) begin
				if (j != i) begin
					if (ang[j] < ang[i] || (ang[j] == ang[i] && j < i)) begin
						rank[i] = rank[i] + 2'd1;
					end
				end
			end
		end
		for (int p = 0; p < NUM_CORNERS; p++) begin
			order[p] = '0;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				if (rank[i] == 2'(p)) begin
					order[p] = 2'(i);
				end
			end
			sorted[p] = ang[order[p]];
		end
	end
endmodule

// File: src/qco_select.sv
// quadrant check, 135 degree fallback and final corner selection
`timescale 1ns / 1ps
module qco_select import qco_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                        pass,
	input  corner_set_t                 crn,
	input  logic [1:0]                  order  [NUM_CORNERS],
	input  logic signed [ANGLE_WIDTH:0] sorted [NUM_CORNERS],
	output res_word_t                   res
);
	localparam logic signed [ANGLE_WIDTH:0] QTR =
		signed'((ANGLE_WIDTH+1)'(1) << (ANGLE_WIDTH - 2));
	localparam logic [ANGLE_WIDTH-1:0] TARGET = ANGLE_WIDTH'(3) << (ANGLE_WIDTH - 3);
	localparam logic [ANGLE_WIDTH-1:0] HALF = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
	localparam logic [ANGLE_WIDTH:0] FULL = {1'b1, {ANGLE_WIDTH{1'b0}}};

	logic [1:0]             lu, ru, rd, ld;
	logic                   h_lu, h_ru, h_rd, h_ld;
	logic [ANGLE_WIDTH-1:0] u;
	logic [ANGLE_WIDTH:0]   d;
	logic [ANGLE_WIDTH:0]   best_d;
	logic [1:0]             best;

	always_comb begin
		lu = '0; ru = '0; rd = '0; ld = '0;
		h_lu = 1'b0; h_ru = 1'b0; h_rd = 1'b0; h_ld = 1'b0;
		best = '0;
		best_d = '1;
		u = '0;
		d = '0;
		for (int p = 0; p < NUM_CORNERS; p++) begin
			if (sorted[p] > QTR) begin
				lu = order[p]; h_lu = 1'b1;
			end else if (sorted[p] > 0) begin
				ru = order[p]; h_ru = 1'b1;
			end else if (sorted[p] > -QTR) begin
				rd = order[p]; h_rd = 1'b1;
			end else begin
				ld = order[p]; h_ld = 1'b1;
			end
			u = ANGLE_WIDTH'(sorted[p]) - TARGET;
			d = (u >= HALF) ? FULL - {1'b0, u} : {1'b0, u};
			if (d < best_d) begin
				best_d = d;
				best = 2'(p);
			end
		end

		res.crn = crn;
		priority if (pass) begin
			res.status = ST_PASS;
		end else if (h_lu && h_ru && h_rd && h_ld) begin
			res.status = ST_QUAD;
			res.crn[0] = crn[lu];
			res.crn[1] = crn[ru];
			res.crn[2] = crn[rd];
			res.crn[3] = crn[ld];
		end else begin
			res.status = ST_FALLBACK;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				res.crn[i] = crn[order[best + 2'(i)]];
			end
		end
	end
endmodule

// File: src/quad_corner_ordering_unit.sv
// top level: corner ordering pipeline with output skid buffer
//
//  channel  dir  word
//  cand     in   both_valid, center_point, ref_point, corner_a..corner_d
//  result   out  status, out_first, out_second, out_third, out_fourth
//
// one word per cycle sustained while result accepts words; the cordic lanes
// run one iteration per stage
// arst_n clears the valid bits of all stages and both output registers
// a stall on result fills the skid register, then holds the whole pipeline
`timescale 1ns / 1ps
module quad_corner_ordering_unit import qco_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qco_in_if.sink     cand,
	qco_out_if.source  result
);
	localparam int CW = COORD_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam int NVLD = AW + 4;
	localparam logic [AW-1:0] HALF = {1'b1, {(AW-1){1'b0}}};

	logic [NVLD-1:0] vld_q;
	logic            run;
	logic            take;
	logic            new_v;
	res_word_t       res_q, skid_q, sel_res;
	logic            res_vld_q, skid_vld_q;

	logic [63:0]              w [NUM_LANES+1];
	logic signed [CW-1:0]     px [NUM_LANES+1];
	logic signed [CW-1:0]     py [NUM_LANES+1];
	logic signed [CW:0]       dx_s1 [NUM_LANES];
	logic signed [CW:0]       dy_s1 [NUM_LANES];
	side_t                    side_s1;
	side_t                    side_s [0:AW];
	logic [AW-1:0]            z [NUM_LANES];
	logic [AW-1:0]            r [NUM_CORNERS];
	logic signed [AW:0]       ang_s2 [NUM_CORNERS];
	side_t                    side_s2;
	logic [1:0]               order [NUM_CORNERS];
	logic signed [AW:0]       sorted [NUM_CORNERS];
	logic [1:0]               order_s3 [NUM_CORNERS];
	logic signed [AW:0]       sorted_s3 [NUM_CORNERS];
	side_t                    side_s3;

	assign run = !skid_vld_q;
	assign cand.ready = run;
	assign take = res_vld_q && result.ready;
	assign new_v = run && vld_q[NVLD-1];

	// lane 0 is the reference, lanes 1..4 the corners; entry 5 is the centre
	assign w[0] = {32'b0, cand.ref_point};
	assign w[1] = {32'b0, cand.corner_a};
	assign w[2] = {32'b0, cand.corner_b};
	assign w[3] = {32'b0, cand.corner_c};
	assign w[4] = {32'b0, cand.corner_d};
	assign w[5] = {32'b0, cand.center_point};

	always_comb begin
		for (int l = 0; l <= NUM_LANES; l++) begin
			px[l] = signed'(w[l][CW +: CW]);
			py[l] = signed'(w[l][0 +: CW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (run) begin
			vld_q <= {vld_q[NVLD-2:0], cand.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				dx_s1[l] <= (CW+1)'(px[l]) - (CW+1)'(px[NUM_LANES]);
				dy_s1[l] <= (CW+1)'(py[l]) - (CW+1)'(py[NUM_LANES]);
			end
			side_s1.pass <= !cand.both_valid ||
				(px[0] == px[NUM_LANES] && py[0] == py[NUM_LANES]);
			side_s1.crn <= {cand.corner_d, cand.corner_c, cand.corner_b, cand.corner_a};
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		qco_cordic #(
			.COORD_WIDTH(CW),
			.ANGLE_WIDTH(AW)
		) u_cordic (
			.clk   (clk),
			.en    (run),
			.dx    (dx_s1[l]),
			.dy    (dy_s1[l]),
			.angle (z[l])
		);
	end

	always_ff @(posedge clk) begin
		if (run) begin
			side_s[0] <= side_s1;
			for (int k = 1; k <= AW; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// relative angle wrapped to (-pi, pi]
	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			r[i] = z[i+1] - z[0];
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			for (int i = 0; i < NUM_CORNERS; i++) begin
				ang_s2[i] <= signed'({r[i] > HALF, r[i]});
			end
			side_s2 <= side_s[AW];
		end
	end

	qco_rank #(
		.ANGLE_WIDTH(AW)
	) u_rank (
		.ang    (ang_s2),
		.order  (order),
		.sorted (sorted)
	);

	always_ff @(posedge clk) begin
		if (run) begin
			order_s3 <= order;
			sorted_s3 <= sorted;
			side_s3 <= side_s2;
		end
	end

	qco_select #(
		.ANGLE_WIDTH(AW)
	) u_select (
		.pass   (side_s3.pass),
		.crn    (side_s3.crn),
		.order  (order_s3),
		.sorted (sorted_s3),
		.res    (sel_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!res_vld_q || take) begin
			res_vld_q <= skid_vld_q || new_v;
			skid_vld_q <= 1'b0;
		end else if (new_v) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_vld_q || take) begin
			res_q <= skid_vld_q ? skid_q : sel_res;
		end else if (new_v) begin
			skid_q <= sel_res;
		end
	end

	assign result.valid = res_vld_q;
	assign result.status = res_q.status;
	assign result.out_first = res_q.crn[0];
	assign result.out_second = res_q.crn[1];
	assign result.out_third = res_q.crn[2];
	assign result.out_fourth = res_q.crn[3];
endmodule

// File: src/qco_checker.sv
// port-level assertions for the corner ordering unit, bound to the top level
`timescale 1ns / 1ps
module qco_checker import qco_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] out_first
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(status))
		else $error("result word changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_PASS || status == ST_QUAD || status == ST_FALLBACK))
		else $error("undefined status code");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with empty output");

	a_ready_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready && in_valid || out_valid && !out_ready))
		else $error("input ready fell without an output stall");
endmodule

bind quad_corner_ordering_unit qco_checker u_qco_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cand.valid),
	.in_ready  (cand.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.status    (result.status),
	.out_first (result.out_first)
);

// File: tb/sv/quad_corner_ordering_unit_tb.sv
// self-checking testbench for the corner ordering unit: directed table then random words
`timescale 1ns / 1ps
module quad_corner_ordering_unit_tb;
	import qco_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int AW = ANGLE_WIDTH_DEF;
	localparam int LATENCY = AW + 5;
	localparam int NUM_RANDOM = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [31:0] ANG_FULL = 32'd1 << AW;
	localparam logic [31:0] ANG_MASK = ANG_FULL - 1;
	localparam logic [31:0] ANG_HALF = 32'd1 << (AW - 1);
	localparam int ANG_QUARTER = 1 << (AW - 2);
	localparam int ANG_TARGET = 3 << (AW - 3);

	typedef struct packed {
		logic        both_valid;
		logic [31:0] center_point;
		logic [31:0] ref_point;
		logic [3:0][31:0] crn;
	} cand_word_t;

	typedef struct {
		cand_word_t w;
		logic       known;
		res_word_t  res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   errors = 0;
	bit   stim_done = 1'b0;
	bit   long_hold = 1'b0;

	qco_in_if  cand ();
	qco_out_if result ();

	quad_corner_ordering_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand.sink),
		.result (result.source)
	);

	res_word_t pending_results[$];
	row_t      rows[$];

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL quad_corner_ordering_unit");
			$finish;
		end
	end

	function automatic longint coord(logic [31:0] w, bit hi);
		logic [15:0] v;
		v = hi ? w[31:16] : w[15:0];
		return longint'($signed(v));
	endfunction

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] atan_step(int i);
		logic [31:0] tab [24];
		logic [32:0] t;
		tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		t = {1'b0, tab[i]} + (33'd1 << (31 - AW));
		return 32'(t >> (32 - AW));
	endfunction

	function automatic logic [31:0] bin_angle(longint dx, longint dy);
		longint x, y, xs, ys;
		logic [31:0] z;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = ANG_HALF;
		end
		for (int i = 0; i < AW && i < 24; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += atan_step(i);
			end else if (y < 0) begin
				x -= ys; y += xs; z -= atan_step(i);
			end else break;
		end
		return z & ANG_MASK;
	endfunction

	function automatic res_word_t order_corners(cand_word_t w);
		res_word_t r;
		longint cx, cy, rx, ry;
		logic [31:0] zr, zc, u, d, best_d;
		int ang[4], ord[4];
		int k, j, best, lu, ru, rd, ld;
		bit h_lu, h_ru, h_rd, h_ld;
		cx = coord(w.center_point, 1); cy = coord(w.center_point, 0);
		rx = coord(w.ref_point, 1); ry = coord(w.ref_point, 0);
		r.status = ST_PASS;
		for (int i = 0; i < 4; i++) r.crn[3 - i] = w.crn[3 - i];
		if (!w.both_valid || (rx == cx && ry == cy)) return r;
		zr = bin_angle(rx - cx, ry - cy);
		for (int i = 0; i < 4; i++) begin
			zc = bin_angle(coord(w.crn[3 - i], 1) - cx, coord(w.crn[3 - i], 0) - cy);
			u = (zc - zr) & ANG_MASK;
			ang[i] = (u > ANG_HALF) ? int'(u) - int'(ANG_FULL) : int'(u);
			ord[i] = i;
		end
		for (int i = 1; i < 4; i++) begin
			k = ord[i];
			j = i - 1;
			while (j >= 0 && ang[k] < ang[ord[j]]) begin
				ord[j + 1] = ord[j];
				j--;
			end
			ord[j + 1] = k;
		end
		h_lu = 0; h_ru = 0; h_rd = 0; h_ld = 0;
		lu = 0; ru = 0; rd = 0; ld = 0;
		for (int i = 0; i < 4; i++) begin
			if (ang[ord[i]] > ANG_QUARTER) begin lu = ord[i]; h_lu = 1; end
			else if (ang[ord[i]] > 0) begin ru = ord[i]; h_ru = 1; end
			else if (ang[ord[i]] > -ANG_QUARTER) begin rd = ord[i]; h_rd = 1; end
			else begin ld = ord[i]; h_ld = 1; end
		end
		if (h_lu && h_ru && h_rd && h_ld) begin
			r.status = ST_QUAD;
			r.crn[3] = w.crn[3 - lu];
			r.crn[2] = w.crn[3 - ru];
			r.crn[1] = w.crn[3 - rd];
			r.crn[0] = w.crn[3 - ld];
			return r;
		end
		best = 0;
		best_d = 32'hFFFF_FFFF;
		for (int i = 0; i < 4; i++) begin
			u = 32'(ang[ord[i]] - ANG_TARGET) & ANG_MASK;
			d = (u >= ANG_HALF) ? ANG_FULL - u : u;
			if (d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		r.status = ST_FALLBACK;
		for (int i = 0; i < 4; i++) r.crn[3 - i] = w.crn[3 - ord[(best + i) & 3]];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
	endtask

	function automatic logic [31:0] pk(int x, int y);
		return {x[15:0], y[15:0]};
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] rand_near(logic [31:0] c, int span);
		return pk(int'(coord(c, 1)) + $urandom_range(0, 2 * span) - span,
			int'(coord(c, 0)) + $urandom_range(0, 2 * span) - span);
	endfunction

	task automatic add_row(cand_word_t w, logic known, res_word_t res);
		row_t r;
		r.w = w;
		r.known = known;
		r.res = res;
		rows.insert(rows.size(), r);
	endtask

	task automatic build_table();
		cand_word_t w;
		res_word_t r;
		logic [31:0] c;
		// not valid: pass through
		w = '{1'b0, 32'h0, 32'h0010_0000, '{32'hFFFF_FFFF, 32'h0, 32'h8000_8000, 32'h7FFF_7FFF}};
		r = '{ST_PASS, w.crn};
		add_row(w, 1, r);
		// reference on centre
		w = '{1'b1, 32'h1234_5678, 32'h1234_5678, '{32'h1, 32'h2, 32'h3, 32'h4}};
		r = '{ST_PASS, w.crn};
		add_row(w, 1, r);
		// square, reference to the right: lu ru rd ld
		w.both_valid = 1; w.center_point = 0; w.ref_point = pk(16, 0);
		w.crn = '{pk(-100, -100), pk(100, 100), pk(-100, 100), pk(100, -100)};
		r = '{ST_QUAD, '{pk(-100, 100), pk(100, 100), pk(100, -100), pk(-100, -100)}};
		add_row(w, 1, r);
		// extremes of the coordinate range
		w.center_point = pk(32767, -32768); w.ref_point = pk(-32768, 32767);
		w.crn = '{pk(32767, 32767), pk(-32768, -32768), pk(-32768, 32767), pk(32767, -32768)};
		add_row(w, 0, r);
		w.center_point = pk(-32768, 32767); w.ref_point = pk(32767, -32768);
		add_row(w, 0, r);
		// corners on centre, all same angle, ties
		w.center_point = pk(5, 5); w.ref_point = pk(5, 90);
		w.crn = '{pk(5, 5), pk(5, 5), pk(5, 5), pk(5, 5)};
		add_row(w, 0, r);
		// boundaries at quadrant limits and at -pi
		w.center_point = 0; w.ref_point = pk(0, 50);
		w.crn = '{pk(0, -40), pk(40, 0), pk(-40, 0), pk(0, 40)};
		add_row(w, 0, r);
		w.ref_point = pk(-50, 0);
		w.crn = '{pk(50, 0), pk(50, 0), pk(-7, 3), pk(3, -7)};
		add_row(w, 0, r);
		// two corners equidistant from 135 degrees
		w.ref_point = pk(30, 0);
		w.crn = '{pk(0, 30), pk(-30, 0), pk(0, 30), pk(-30, 0)};
		add_row(w, 0, r);
		// every input bit both ways
		w = '{1'b1, 32'hFFFF_FFFF, 32'h0, '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0}};
		add_row(w, 0, r);
		w = '{1'b1, 32'h0, 32'hFFFF_FFFF, '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF}};
		add_row(w, 0, r);
		w = '{1'b1, 32'hAAAA_5555, 32'h5555_AAAA, '{32'hAAAA_AAAA, 32'h5555_5555,
			32'h8000_7FFF, 32'h7FFF_8000}};
		add_row(w, 0, r);
		for (int i = 0; i < 8; i++) begin
			c = $urandom;
			w.both_valid = 1;
			w.center_point = c;
			w.ref_point = rand_near(c, 3);
			for (int k = 0; k < 4; k++) w.crn[k] = rand_near(c, 2);
			add_row(w, 0, r);
		end
	endtask

	task automatic send(cand_word_t w);
		cand.valid <= 1'b1;
		cand.both_valid <= w.both_valid;
		cand.center_point <= w.center_point;
		cand.ref_point <= w.ref_point;
		cand.corner_a <= w.crn[3];
		cand.corner_b <= w.crn[2];
		cand.corner_c <= w.crn[1];
		cand.corner_d <= w.crn[0];
		@(posedge clk);
		while (!cand.ready) @(posedge clk);
		pending_results.insert(pending_results.size(), order_corners(w));
	endtask

	function automatic cand_word_t rand_word();
		cand_word_t w;
		logic [31:0] c;
		int p, span;
		p = $urandom_range(0, 99);
		c = $urandom;
		span = (p < 50) ? 2000 : ((p < 70) ? 6 : 30000);
		w.both_valid = ($urandom_range(0, 9) != 0);
		w.center_point = (p < 50) ? pk($urandom_range(0, 4000) - 2000,
			$urandom_range(0, 4000) - 2000) : c;
		w.ref_point = ($urandom_range(0, 19) == 0) ? w.center_point
			: rand_near(w.center_point, span);
		for (int k = 0; k < 4; k++)
			w.crn[k] = (p >= 95) ? $urandom : rand_near(w.center_point, span);
		return w;
	endfunction

	initial begin
		cand_word_t w;
		int g;
		cand.valid = 1'b0;
		cand.both_valid = 1'b0;
		cand.center_point = '0;
		cand.ref_point = '0;
		cand.corner_a = '0;
		cand.corner_b = '0;
		cand.corner_c = '0;
		cand.corner_d = '0;
		build_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].w);
			if (rows[i].known && order_corners(rows[i].w) != rows[i].res)
				report("table row", i, 0);
			if (rows[i].known) pending_results[$] = rows[i].res;
			cand.valid <= 1'b0;
			@(posedge clk);
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == 400) long_hold = 1'b1;
			w = rand_word();
			send(w);
			g = (n >= 800 && n < 1000) ? 0 : gap_len();
			if (g > 0) begin
				cand.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		cand.valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int g;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				result.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			g = (cycles % 3000 < 1000) ? 0 : gap_len();
			if (g > 0) begin
				result.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) report("unexpected word", result.status, 0);
			else begin
				want = pending_results.pop_front();
				if (result.status != want.status) report("status", result.status, want.status);
				if (result.out_first != want.crn[3]) report("out_first", result.out_first, want.crn[3]);
				if (result.out_second != want.crn[2])
					report("out_second", result.out_second, want.crn[2]);
				if (result.out_third != want.crn[1]) report("out_third", result.out_third, want.crn[1]);
				if (result.out_fourth != want.crn[0])
					report("out_fourth", result.out_fourth, want.crn[0]);
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);
		if (errors == 0) $display("PASS quad_corner_ordering_unit");
		else $display("FAIL quad_corner_ordering_unit");
		$finish;
	end

endmodule

// File: filelist.f
src/qco_pkg.sv
src/qco_in_if.sv
src/qco_out_if.sv
src/qco_cordic.sv
src/qco_rank.sv
src/qco_select.sv
src/quad_corner_ordering_unit.sv
src/qco_checker.sv
tb/sv/quad_corner_ordering_unit_tb.sv
